### design/rtkv_pkg.sv
// ----------------------------------------------------------------------------
// rtkv_pkg
// shared constants and types of the radix trie key-value map
// ----------------------------------------------------------------------------
package rtkv_pkg;
  localparam int NodeCount = 256;
  localparam int NodeW = 8;
  localparam int DigitW = 4;
  localparam int Radix = 16;
  localparam int Levels = 8;
  localparam int ValueW = 32;
  localparam int KeyW = 32;
  localparam int CountW = 12;
  localparam int SlotAw = NodeW + DigitW;

  localparam logic [1:0] OpFind = 2'd0;
  localparam logic [1:0] OpInsert = 2'd1;
  localparam logic [1:0] OpRemove = 2'd2;
  localparam logic [1:0] OpNop = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StZero = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  // node record: child marks, value marks, parent link
  typedef struct packed {
    logic [Radix-1:0] child;
    logic [Radix-1:0] vmark;
    logic [NodeW-1:0] parent;
    logic [DigitW-1:0] pslot;
  } node_t;
  localparam int NodeRecW = $bits(node_t);
endpackage

### design/rtkv_ram.sv
// ----------------------------------------------------------------------------
// rtkv_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module rtkv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

### design/radix_trie_key_value_map_unit.sv
// ----------------------------------------------------------------------------
// radix_trie_key_value_map_unit
// 32-bit key to value map held as a 16-way, 8-level trie in node memories
// ----------------------------------------------------------------------------
// steps: each inner level is a node read, then a slot read; insert adds a free list
//   read and a link step per node made, remove a parent read and write per node
//   freed upward; a waiting result holds the block at the end
// throughput: one beat in flight; the result sits in its own output register
// reset: after rst_ni the block sweeps the node memory and free list
//   (clearing marks, loading nodes 1 to 255) before tready rises
module radix_trie_key_value_map_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // op[1:0], key[33:2], value[65:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // status[1:0], found_value[33:2], entry_count[45:34]
);
  import rtkv_pkg::*;

  localparam logic [3:0] SInit   = 4'd0;
  localparam logic [3:0] SIdle   = 4'd1;
  localparam logic [3:0] SRead   = 4'd2;  // node memory read issued, wait
  localparam logic [3:0] SEval   = 4'd3;  // node record available
  localparam logic [3:0] SAlloc  = 4'd4;  // free list read issued
  localparam logic [3:0] SMake   = 4'd5;  // fresh node known, link it
  localparam logic [3:0] SSlotRd = 4'd6;  // slot read wait (child number or value)
  localparam logic [3:0] SSlotEv = 4'd7;
  localparam logic [3:0] SUpRd   = 4'd8;  // parent read wait during trim
  localparam logic [3:0] SUpEv   = 4'd9;
  localparam logic [3:0] SOut    = 4'd10;
  localparam logic [3:0] SUpWr   = 4'd11; // parent record in, clear its child mark

  logic [3:0] state_q, state_d;

  // node memory
  logic              nd_we;
  logic [NodeW-1:0]  nd_addr;
  node_t             nd_wdata, nd_rdata;
  // slot memory (child number or value)
  logic              sl_we;
  logic [SlotAw-1:0] sl_addr;
  logic [ValueW-1:0] sl_wdata, sl_rdata;
  // free stack
  logic              fl_we;
  logic [NodeW-1:0]  fl_addr;
  logic [NodeW-1:0]  fl_wdata, fl_rdata;

  rtkv_ram #(.Width(NodeRecW), .Depth(NodeCount)) u_node (
    .clk_i, .we_i(nd_we), .addr_i(nd_addr), .wdata_i(nd_wdata), .rdata_o(nd_rdata)
  );
  rtkv_ram #(.Width(ValueW), .Depth(NodeCount*Radix)) u_slot (
    .clk_i, .we_i(sl_we), .addr_i(sl_addr), .wdata_i(sl_wdata), .rdata_o(sl_rdata)
  );
  rtkv_ram #(.Width(NodeW), .Depth(NodeCount)) u_free (
    .clk_i, .we_i(fl_we), .addr_i(fl_addr), .wdata_i(fl_wdata), .rdata_o(fl_rdata)
  );

  logic [1:0]        op_q, op_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [ValueW-1:0] val_q, val_d;
  logic [2:0]        lvl_q, lvl_d;
  logic [NodeW-1:0]  node_q, node_d;      // node being visited
  node_t             rec_q, rec_d;        // held copy of current node record
  logic [NodeW-1:0]  fresh_q, fresh_d;
  logic [NodeW:0]    fcnt_q, fcnt_d;      // free node count
  logic [CountW-1:0] ecnt_q, ecnt_d;
  logic [NodeW-1:0]  init_q, init_d;
  logic [1:0]        st_q, st_d;
  logic [ValueW-1:0] fv_q, fv_d;
  logic              ov_q, ov_d;
  // result beat held stable while it waits for the receiver
  logic [CountW+ValueW+1:0] out_q, out_d;

  logic [DigitW-1:0] dig;
  assign dig = key_q[KeyW-1-lvl_q*DigitW -: DigitW];

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, out_q};

  always_comb begin
    state_d = state_q; op_d = op_q; key_d = key_q; val_d = val_q;
    lvl_d = lvl_q; node_d = node_q; rec_d = rec_q; fresh_d = fresh_q;
    fcnt_d = fcnt_q; ecnt_d = ecnt_q; init_d = init_q;
    st_d = st_q; fv_d = fv_q; ov_d = ov_q; out_d = out_q;
    nd_we = 1'b0; nd_addr = node_q; nd_wdata = rec_q;
    sl_we = 1'b0; sl_addr = {node_q, dig}; sl_wdata = val_q;
    fl_we = 1'b0; fl_addr = fcnt_q[NodeW-1:0]; fl_wdata = node_q;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    unique case (state_q)
      SInit: begin
        // clear node marks and load the free stack
        nd_we = 1'b1; nd_addr = init_q; nd_wdata = '0;
        fl_we = 1'b1; fl_addr = init_q; fl_wdata = init_q + 8'd1;
        init_d = init_q + 8'd1;
        if (init_q == 8'(NodeCount-1)) state_d = SIdle;
      end
      SIdle: begin
        if (s_axis_tvalid) begin
          op_d = s_axis_tdata[1:0];
          key_d = s_axis_tdata[33:2];
          val_d = s_axis_tdata[65:34];
          lvl_d = '0; node_d = '0;
          st_d = StNotFound; fv_d = '0;
          if (s_axis_tdata[1:0] == OpNop) state_d = SOut;
          else if (s_axis_tdata[1:0] == OpInsert && s_axis_tdata[65:34] == '0) begin
            st_d = StZero; state_d = SOut;
          end else begin
            nd_addr = '0; state_d = SRead;
          end
        end
      end
      SRead: state_d = SEval;
      SEval: begin
        rec_d = (state_q == SEval) ? nd_rdata : rec_q;
        if (lvl_q == 3'(Levels-1)) begin
          // leaf node
          if (op_q == OpInsert) begin
            if (!nd_rdata.vmark[dig] && ecnt_q != '1) ecnt_d = ecnt_q + 1'b1;
            nd_we = 1'b1; nd_wdata = nd_rdata; nd_wdata.vmark[dig] = 1'b1;
            sl_we = 1'b1; st_d = StOk; state_d = SOut;
          end else if (!nd_rdata.vmark[dig]) begin
            state_d = SOut;
          end else if (op_q == OpFind) begin
            state_d = SSlotRd;
          end else begin
            nd_we = 1'b1; nd_wdata = nd_rdata; nd_wdata.vmark[dig] = 1'b0;
            rec_d = nd_wdata;
            if (ecnt_q != '0) ecnt_d = ecnt_q - 1'b1;
            st_d = StOk;
            state_d = SUpEv;
          end
        end else if (nd_rdata.child[dig]) begin
          state_d = SSlotRd;
        end else if (op_q != OpInsert) begin
          state_d = SOut;
        end else if (fcnt_q == '0) begin
          st_d = StFull; state_d = SOut;
        end else begin
          fcnt_d = fcnt_q - 1'b1;
          fl_addr = fcnt_d[NodeW-1:0];
          state_d = SAlloc;
        end
      end
      SAlloc: begin
        fresh_d = fl_rdata;
        state_d = SMake;
      end
      SMake: begin
        // link fresh node in parent, then initialise fresh node record
        nd_we = 1'b1;
        nd_wdata = rec_q; nd_wdata.child[dig] = 1'b1;
        rec_d = nd_wdata;
        sl_we = 1'b1; sl_wdata = ValueW'(fresh_q);
        state_d = SSlotEv;
        // mark that the next step writes the fresh record
        fv_d = '1;
      end
      SSlotRd: state_d = SSlotEv;
      SSlotEv: begin
        if (fv_q == '1 && op_q == OpInsert) begin
          // write fresh node record and descend into it
          nd_we = 1'b1; nd_addr = fresh_q;
          nd_wdata.child = '0; nd_wdata.vmark = '0;
          nd_wdata.parent = node_q; nd_wdata.pslot = dig;
          fv_d = '0;
          node_d = fresh_q; lvl_d = lvl_q + 3'd1;
          rec_d = nd_wdata;
          state_d = SRead;
        end else if (lvl_q == 3'(Levels-1)) begin
          fv_d = sl_rdata; st_d = StOk; state_d = SOut;
        end else begin
          node_d = sl_rdata[NodeW-1:0];
          nd_addr = sl_rdata[NodeW-1:0];
          lvl_d = lvl_q + 3'd1;
          state_d = SRead;
        end
      end
      SUpEv: begin
        // rec_q holds the updated record of node_q
        if (node_q == '0 || rec_q.child != '0 || rec_q.vmark != '0) begin
          state_d = SOut;
        end else begin
          fl_addr = fcnt_q[NodeW-1:0]; fl_wdata = node_q;
          if (fcnt_q != (NodeW+1)'(NodeCount)) fcnt_d = fcnt_q + 1'b1;
          fl_we = (fcnt_q != (NodeW+1)'(NodeCount));
          fresh_d = {4'd0, rec_q.pslot};
          nd_addr = rec_q.parent; node_d = rec_q.parent;
          state_d = SUpRd;
        end
      end
      SUpRd: begin
        // wait for the parent record; SUpWr clears its child mark
        state_d = SUpWr;
      end
      SUpWr: begin
        nd_we = 1'b1;
        nd_wdata = nd_rdata; nd_wdata.child[fresh_q[DigitW-1:0]] = 1'b0;
        rec_d = nd_wdata;
        state_d = SUpEv;
      end
      SOut: begin
        if (!ov_q) begin
          ov_d = 1'b1; out_d = {ecnt_q, fv_q, st_q}; state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      init_q  <= '0;
      fcnt_q  <= (NodeW+1)'(NodeCount-1);
      ecnt_q  <= '0;
      ov_q    <= 1'b0;
      fv_q    <= '0;
      out_q   <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      fcnt_q  <= fcnt_d;
      ecnt_q  <= ecnt_d;
      ov_q    <= ov_d;
      fv_q    <= fv_d;
      out_q   <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; key_q <= key_d; val_q <= val_d; lvl_q <= lvl_d;
    node_q <= node_d; rec_q <= rec_d; fresh_q <= fresh_d; st_q <= st_d;
  end
endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stream-level check of the radix trie map: directed and random find, insert
// and remove beats, compared against a behavioural trie with its own pool
// ----------------------------------------------------------------------------
module tb;
  import rtkv_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int Tail = 64;

  // first field in the low bits, as on the bus
  typedef struct packed {
    logic [31:0] value;
    logic [31:0] key;
    logic [1:0]  op;
  } req_t;

  typedef struct packed {
    logic [11:0] count;
    logic [31:0] found;
    logic [1:0]  status;
  } rsp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // op[1:0], key[33:2], value[65:34]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // status[1:0], found_value[33:2], entry_count[45:34]

  radix_trie_key_value_map_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // behavioural trie state
  logic [Radix-1:0] tr_child [NodeCount];
  logic [Radix-1:0] tr_vmark [NodeCount];
  logic [31:0]      tr_slot  [NodeCount][Radix];
  logic [NodeW-1:0] tr_parent [NodeCount];
  logic [DigitW-1:0] tr_pslot [NodeCount];
  logic [NodeW-1:0] tr_free [NodeCount];
  int               tr_free_n;
  int               tr_entries;

  req_t pending_beats[$];
  rsp_t expected_rsps[$];
  logic [31:0] used_keys[$];

  int  cycles, mismatches, results_seen;
  bit  quiet_tail, rx_hold, tx_pause, tx_taken;
  int  tx_gap, rx_gap;
  int  op_seen[4];
  int  st_seen[4];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [3:0] digit_of(logic [31:0] key, int lvl);
    return key[(7 - lvl) * 4 +: 4];
  endfunction

  function automatic bit node_is_empty(int n);
    return tr_child[n] == '0 && tr_vmark[n] == '0;
  endfunction

  // walk to the leaf; creates nodes when grow is set, flags pool exhaustion
  function automatic bit walk_trie(logic [31:0] key, bit grow, output int leaf,
                                   output bit full);
    int node, fresh;
    logic [3:0] d;
    node = 0;
    full = 1'b0;
    leaf = 0;
    for (int lvl = 0; lvl < Levels - 1; lvl++) begin
      d = digit_of(key, lvl);
      if (!tr_child[node][d]) begin
        if (!grow) return 1'b0;
        if (tr_free_n == 0) begin
          full = 1'b1;
          return 1'b0;
        end
        tr_free_n--;
        fresh = tr_free[tr_free_n];
        tr_child[fresh] = '0;
        tr_vmark[fresh] = '0;
        tr_parent[fresh] = node[NodeW-1:0];
        tr_pslot[fresh] = d;
        tr_slot[node][d] = fresh;
        tr_child[node][d] = 1'b1;
      end
      node = tr_slot[node][d][NodeW-1:0];
    end
    leaf = node;
    return 1'b1;
  endfunction

  function automatic rsp_t apply_map_op(req_t r);
    rsp_t o;
    int leaf, node, up;
    bit full;
    logic [3:0] d;
    o = '{status: StNotFound, found: '0, count: '0};
    d = digit_of(r.key, Levels - 1);
    case (r.op)
      OpFind: begin
        if (walk_trie(r.key, 1'b0, leaf, full) && tr_vmark[leaf][d]) begin
          o.status = StOk;
          o.found = tr_slot[leaf][d];
        end
      end
      OpInsert: begin
        if (r.value == '0) begin
          o.status = StZero;
        end else if (walk_trie(r.key, 1'b1, leaf, full)) begin
          if (!tr_vmark[leaf][d] && tr_entries < 4095) tr_entries++;
          tr_slot[leaf][d] = r.value;
          tr_vmark[leaf][d] = 1'b1;
          o.status = StOk;
        end else begin
          o.status = StFull;
        end
      end
      OpRemove: begin
        if (walk_trie(r.key, 1'b0, leaf, full) && tr_vmark[leaf][d]) begin
          tr_vmark[leaf][d] = 1'b0;
          if (tr_entries > 0) tr_entries--;
          node = leaf;
          // trim empty nodes upward, the root stays
          while (node != 0 && node_is_empty(node)) begin
            up = tr_parent[node];
            tr_child[up][tr_pslot[node]] = 1'b0;
            if (tr_free_n < NodeCount) begin
              tr_free[tr_free_n] = node[NodeW-1:0];
              tr_free_n++;
            end
            node = up;
          end
          o.status = StOk;
        end
      end
      default: ;
    endcase
    o.count = tr_entries[11:0];
    return o;
  endfunction

  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    if (used_keys.size() > 0 && $urandom_range(0, 99) < 60)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    case ($urandom_range(0, 2))
      0: k = $urandom();
      // shared high digits keep paths overlapping
      1: k = {20'hA5C3E, 12'($urandom())};
      default: k = {24'h13579B, 8'($urandom())};
    endcase
    used_keys.push_back(k);
    if (used_keys.size() > 200) void'(used_keys.pop_front());
    return k;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_beat(logic [1:0] op, logic [31:0] key, logic [31:0] value);
    pending_beats.push_back('{op: op, key: key, value: value});
  endtask

  // input handshake seen at the last rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tx_taken <= 1'b0;
    else tx_taken <= s_axis_tvalid && s_axis_tready;
  end

  // sender: offers beats from the queue, with random gaps
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      tx_gap        <= 0;
    end else begin
      if (tx_taken) void'(pending_beats.pop_front());
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (s_axis_tvalid && !tx_taken) begin
        // hold the beat until taken
      end else if (!tx_pause && pending_beats.size() > 0) begin
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
          tx_gap <= $urandom_range(1, 15);
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'd0, pending_beats[0].value, pending_beats[0].key,
                           pending_beats[0].op};
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready with bursts of back-pressure and one long hold
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap        <= 0;
    end else if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      rx_gap <= $urandom_range(1, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // predict on accepted input, check on accepted output
  always @(posedge clk_i) begin
    rsp_t got, want;
    req_t acc;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        acc = s_axis_tdata[65:0];
        expected_rsps.push_back(apply_map_op(acc));
        op_seen[acc.op]++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[45:0];
        results_seen++;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = expected_rsps.pop_front();
          st_seen[want.status]++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d: expected st=%0d val=%h cnt=%0d, got st=%0d val=%h cnt=%0d",
                       results_seen, want.status, want.found, want.count,
                       got.status, got.found, got.count);
          end
        end
      end
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] k;
    rst_ni = 1'b0;
    cycles = 0;
    mismatches = 0;
    results_seen = 0;
    quiet_tail = 1'b0;
    rx_hold = 1'b0;
    tx_pause = 1'b0;
    for (int n = 0; n < NodeCount; n++) begin
      tr_child[n] = '0;
      tr_vmark[n] = '0;
    end
    for (int n = 0; n < NodeCount - 1; n++) tr_free[n] = NodeW'(n + 1);
    tr_free_n = NodeCount - 1;
    tr_entries = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    foreach (st_seen[i]) st_seen[i] = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: miss, zero value, extremes, update, unused op, remove
    add_beat(OpFind, '0, '0);
    add_beat(OpRemove, '1, '0);
    add_beat(OpInsert, 32'h1234_5678, '0);
    add_beat(OpInsert, '0, '1);
    add_beat(OpInsert, '1, 32'h0000_0001);
    add_beat(OpInsert, 32'hAAAA_AAAA, 32'h5555_5555);
    add_beat(OpInsert, 32'h5555_5555, 32'hAAAA_AAAA);
    add_beat(OpFind, '0, 32'hDEAD_BEEF);
    add_beat(OpFind, '1, '0);
    add_beat(OpInsert, '1, 32'h8000_0000);
    add_beat(OpFind, '1, '0);
    add_beat(OpNop, '1, '1);
    add_beat(OpRemove, '0, '0);
    add_beat(OpFind, '0, '0);
    add_beat(OpRemove, '0, '0);
    add_beat(OpRemove, 32'hAAAA_AAAA, '0);
    add_beat(OpRemove, 32'h5555_5555, '0);
    add_beat(OpRemove, '1, '0);
    add_beat(OpFind, 32'h5555_5555, '0);
    // pool exhaustion: a new second digit costs six nodes, a new top digit seven
    for (int i = 0; i < 48; i++) add_beat(OpInsert, {i[7:0], 24'h0}, 32'h100 + i);
    add_beat(OpFind, 32'h2000_0000, '0);
    for (int i = 0; i < 48; i++) add_beat(OpRemove, {i[7:0], 24'h0}, '0);
    add_beat(OpInsert, 32'h2700_0000, 32'h77);
    add_beat(OpRemove, 32'h2700_0000, '0);

    // random: mostly inserts and lookups of reused keys
    for (int i = 0; i < 800; i++) begin
      k = pick_key();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add_beat(OpInsert, k, pick_value());
        4, 5, 6: add_beat(OpFind, k, $urandom());
        7, 8: add_beat(OpRemove, k, $urandom());
        default: add_beat(2'($urandom_range(0, 3)), $urandom(), $urandom());
      endcase
      if (i == 200) begin
        // long receiver hold so the block backs up
        wait (pending_beats.size() < 100);
        rx_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      if (i == 400) begin
        // sender pause until everything drains
        wait (pending_beats.size() == 0);
        tx_pause = 1'b1;
        wait (expected_rsps.size() == 0);
        @(negedge clk_i) tx_pause = 1'b0;
      end
      if (i == 700) quiet_tail = 1'b1;
    end

    wait (pending_beats.size() == 0 && expected_rsps.size() == 0);
    repeat (Tail) @(posedge clk_i);
    $display("covered %0d results: ops find/ins/rem/nop %0d/%0d/%0d/%0d", results_seen,
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("statuses ok/miss/zero/full %0d/%0d/%0d/%0d", st_seen[0], st_seen[1],
             st_seen[2], st_seen[3]);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
